// ===== hdl/rgbconv_pkg.sv =====
// Shared types and constants for the RGB 3x3 convolution block.
// No dependencies.
package rgbconv_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COEF_BITS   = 16;
    localparam int KREG_BITS   = 3 * COEF_BITS;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = 16;
    localparam int WIDTH_BITS  = 13;
    localparam int PIX_BITS    = 24;
    // 9 products of 8-bit unsigned by COEF_BITS signed, plus sign and growth
    localparam int ACC_BITS    = COEF_BITS + 8 + 1 + 4;
    localparam int DIV_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KROW_TOP    = 3'd0,
        REG_KROW_MID    = 3'd1,
        REG_KROW_BOTTOM = 3'd2,
        REG_DIVISOR     = 3'd3,
        REG_FRAME_WIDTH = 3'd4,
        REG_FRAME_HEIGHT = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0]          red_out;
        logic [7:0]          green_out;
        logic [7:0]          blue_out;
        logic [COL_BITS-1:0] out_column;
        logic [ROW_BITS-1:0] out_row;
        logic                last_of_run;
        logic                frame_done;
    } result_t;

    // control from sequencer to the divider
    typedef struct packed {
        logic start;
        logic [DIV_BITS-1:0] divisor;
    } div_ctrl_t;

endpackage

// ===== hdl/rgbconv_div.sv =====
// Bit-serial signed divider, truncating toward zero, saturating to 0..255.
// Depends on rgbconv_pkg.
module rgbconv_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  rgbconv_pkg::div_ctrl_t                 ctrl,
    input  logic signed [rgbconv_pkg::ACC_BITS-1:0] dividend,
    output logic                                   done,
    output logic [7:0]                             quotient
);
    localparam int AB = rgbconv_pkg::ACC_BITS;
    localparam int DB = rgbconv_pkg::DIV_BITS;
    localparam int CB = $clog2(AB + 1);

    logic [AB-1:0] num_reg, num_next;
    logic [AB-1:0] rem_reg, rem_next;
    logic [DB-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [AB:0]   trial;
    logic [AB-1:0] shifted;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[AB-2:0], num_reg[AB-1]};
        trial     = {1'b0, shifted} - {{(AB + 1 - DB){1'b0}}, den_reg};
        if (ctrl.start) begin
            num_next  = dividend[AB-1] ? AB'(-dividend) : AB'(dividend);
            neg_next  = dividend[AB-1];
            den_next  = (ctrl.divisor == '0) ? DB'(1) : ctrl.divisor;
            rem_next  = '0;
            cnt_next  = CB'(AB);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[AB]) begin
                rem_next = trial[AB-1:0];
            end else begin
                rem_next = shifted;
            end
            num_next = {num_reg[AB-2:0], ~trial[AB]};
            cnt_next = cnt_reg - CB'(1);
            if (cnt_reg == CB'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = (neg_reg || num_reg == '0) ? 8'd0 :
                      (num_reg > AB'(255)) ? 8'd255 : num_reg[7:0];

endmodule

// ===== hdl/rgb_convolution_clamped_edges.sv =====
// Top level of the RGB 3x3 convolution with clamp-to-edge borders.
// Flow: an input is accepted in ST_IDLE and written to the line store in ST_READ; each
// result then passes through ST_MAC, ST_DIV (3 channels in parallel) and ST_OUT.
// An input yields n = 0, 1, 2 or 4 results, and each result waits in ST_OUT for m_ready;
// one input at a time, as s_ready is high only in ST_IDLE.
// Reset (aresetn, synchronous) restores the register defaults and pixel (0,0).
module rgb_convolution_clamped_edges (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  rgbconv_pkg::pixel_in_t                  s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output rgbconv_pkg::result_t                    m_data,
    input  logic                                    cfg_we,
    input  logic [rgbconv_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rgbconv_pkg::KREG_BITS-1:0]       cfg_wdata
);
    localparam int CB = rgbconv_pkg::COL_BITS;
    localparam int RB = rgbconv_pkg::ROW_BITS;
    localparam int AB = rgbconv_pkg::ACC_BITS;
    localparam int CF = rgbconv_pkg::COEF_BITS;
    localparam int WB = rgbconv_pkg::WIDTH_BITS;
    localparam int PB = rgbconv_pkg::PIX_BITS;
    localparam int MW = rgbconv_pkg::MAX_WIDTH;

    // configuration
    logic [rgbconv_pkg::KREG_BITS-1:0] krow_reg [3];
    logic [rgbconv_pkg::DIV_BITS-1:0]  divisor_reg;
    logic [WB-1:0]                     fwidth_reg;
    logic [RB-1:0]                     fheight_reg;

    // line store: two rows packed per entry, one memory
    logic [2*PB-1:0] line_mem [MW];
    logic [2*PB-1:0] line_rd_reg;

    logic [PB-1:0] win_reg [9];
    logic [PB-1:0] pix_reg;
    logic [CB-1:0] col_reg;
    logic [RB-1:0] row_reg;

    rgbconv_pkg::state_t state_reg, state_next;

    logic [1:0]    nys_reg, nxs_reg, yi_reg, xi_reg;
    logic [3:0]    tap_reg;
    logic signed [AB-1:0] acc_reg [3];
    logic [7:0]    q_reg [3];
    rgbconv_pkg::result_t out_reg;
    logic          out_valid_reg;
    logic [CB-1:0] a_reg;
    logic [RB-1:0] b_reg;

    logic [WB-1:0] w_eff;
    logic [RB-1:0] h_eff;
    logic          s_fire;
    logic          div_done [3];
    logic [7:0]    div_q [3];
    rgbconv_pkg::div_ctrl_t div_ctrl;
    logic          frame_restart;
    logic [1:0]    nys_next_w, nxs_next_w;

    always_comb begin
        if (fwidth_reg < WB'(2)) begin
            w_eff = WB'(2);
        end else if (fwidth_reg > WB'(MW)) begin
            w_eff = WB'(MW);
        end else begin
            w_eff = fwidth_reg;
        end
        h_eff = (fheight_reg < RB'(2)) ? RB'(2) : fheight_reg;
    end

    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == rgbconv_pkg::ST_IDLE);
    assign frame_restart = cfg_we && (cfg_index == rgbconv_pkg::REG_FRAME_WIDTH ||
                                      cfg_index == rgbconv_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            krow_reg[0] <= '0;
            krow_reg[1] <= rgbconv_pkg::KREG_BITS'(65536);
            krow_reg[2] <= '0;
            divisor_reg <= 16'd1;
            fwidth_reg  <= WB'(640);
            fheight_reg <= RB'(480);
        end else if (cfg_we) begin
            case (cfg_index)
                rgbconv_pkg::REG_KROW_TOP:     krow_reg[0] <= cfg_wdata;
                rgbconv_pkg::REG_KROW_MID:     krow_reg[1] <= cfg_wdata;
                rgbconv_pkg::REG_KROW_BOTTOM:  krow_reg[2] <= cfg_wdata;
                rgbconv_pkg::REG_DIVISOR:      divisor_reg <= cfg_wdata[15:0];
                rgbconv_pkg::REG_FRAME_WIDTH:  fwidth_reg  <= cfg_wdata[WB-1:0];
                rgbconv_pkg::REG_FRAME_HEIGHT: fheight_reg <= cfg_wdata[RB-1:0];
                default: ;
            endcase
        end
    end

    // line memory: read on accept, write back in ST_READ
    logic [PB-1:0] mid_px, top_px;
    always_comb begin
        mid_px = (b_reg >= RB'(1)) ? line_rd_reg[PB-1:0] : pix_reg;
        top_px = (b_reg >= RB'(2)) ? line_rd_reg[2*PB-1:PB] : mid_px;
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (state_reg == rgbconv_pkg::ST_READ) begin
            line_mem[a_reg] <= {(b_reg >= RB'(1)) ? line_rd_reg[PB-1:0]
                                                  : line_rd_reg[2*PB-1:PB], pix_reg};
        end
    end

    always_comb begin
        nys_next_w = 2'((b_reg >= RB'(1)) ? 1 : 0) + 2'((b_reg == h_eff - RB'(1)) ? 1 : 0);
        nxs_next_w = 2'((a_reg >= CB'(1)) ? 1 : 0)
                   + 2'(({1'b0, a_reg} == w_eff - WB'(1)) ? 1 : 0);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rgbconv_pkg::ST_IDLE: if (s_fire) state_next = rgbconv_pkg::ST_READ;
            rgbconv_pkg::ST_READ: begin
                if (nys_next_w == 2'd0 || nxs_next_w == 2'd0) begin
                    state_next = rgbconv_pkg::ST_IDLE;
                end else begin
                    state_next = rgbconv_pkg::ST_MAC;
                end
            end
            rgbconv_pkg::ST_MAC: if (tap_reg == 4'd8) state_next = rgbconv_pkg::ST_DIV;
            rgbconv_pkg::ST_DIV: if (div_done[0]) state_next = rgbconv_pkg::ST_OUT;
            rgbconv_pkg::ST_OUT: begin
                if (!out_valid_reg) begin
                    if (yi_reg == nys_reg - 2'd1 && xi_reg == nxs_reg - 2'd1) begin
                        state_next = rgbconv_pkg::ST_IDLE;
                    end else begin
                        state_next = rgbconv_pkg::ST_MAC;
                    end
                end
            end
            default: state_next = rgbconv_pkg::ST_IDLE;
        endcase
    end

    // current tap: r = tap/3, c = tap%3 via small decode
    logic [1:0] tr, tc, wr, wc;
    logic [3:0] widx;
    logic signed [CF-1:0] kcoef;
    logic [PB-1:0] tpx;
    always_comb begin
        case (tap_reg)
            4'd0: begin tr = 2'd0; tc = 2'd0; end
            4'd1: begin tr = 2'd0; tc = 2'd1; end
            4'd2: begin tr = 2'd0; tc = 2'd2; end
            4'd3: begin tr = 2'd1; tc = 2'd0; end
            4'd4: begin tr = 2'd1; tc = 2'd1; end
            4'd5: begin tr = 2'd1; tc = 2'd2; end
            4'd6: begin tr = 2'd2; tc = 2'd0; end
            4'd7: begin tr = 2'd2; tc = 2'd1; end
            default: begin tr = 2'd2; tc = 2'd2; end
        endcase
        wr = (yi_reg != 2'd0 && tr != 2'd2) ? tr + 2'd1 : tr;
        wc = (xi_reg != 2'd0 && tc != 2'd2) ? tc + 2'd1 : tc;
        widx  = 4'(wc) * 4'd3 + 4'(wr);
        tpx   = win_reg[widx];
        kcoef = krow_reg[2'd2 - tr][(2'd2 - tc) * CF +: CF];
    end

    // multiply registered before accumulate
    logic signed [CF+8:0] prod_reg [3];
    logic                 prod_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rgbconv_pkg::ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            prod_v_reg    <= 1'b0;
            tap_reg       <= '0;
        end else begin
            state_reg  <= state_next;
            prod_v_reg <= (state_reg == rgbconv_pkg::ST_MAC);
            if (frame_restart) begin
                col_reg <= '0;
                row_reg <= '0;
            end else if (s_fire) begin
                if ({1'b0, col_reg} + WB'(1) >= w_eff) begin
                    col_reg <= '0;
                    row_reg <= (row_reg + RB'(1) >= h_eff) ? '0 : row_reg + RB'(1);
                end else begin
                    col_reg <= col_reg + CB'(1);
                end
            end
            if (state_reg == rgbconv_pkg::ST_MAC) begin
                tap_reg <= (tap_reg == 4'd8) ? 4'd0 : tap_reg + 4'd1;
            end
            if (state_reg == rgbconv_pkg::ST_DIV && div_done[0]) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            pix_reg <= s_data;
            a_reg   <= col_reg;
            b_reg   <= row_reg;
        end
        if (state_reg == rgbconv_pkg::ST_READ) begin
            nys_reg <= nys_next_w;
            nxs_reg <= nxs_next_w;
            yi_reg  <= '0;
            xi_reg  <= '0;
            if (a_reg == '0) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[c*3+0] <= top_px;
                    win_reg[c*3+1] <= mid_px;
                    win_reg[c*3+2] <= pix_reg;
                end
            end else begin
                for (int c = 0; c < 6; c++) win_reg[c] <= win_reg[c+3];
                win_reg[6] <= top_px;
                win_reg[7] <= mid_px;
                win_reg[8] <= pix_reg;
            end
            for (int ch = 0; ch < 3; ch++) acc_reg[ch] <= '0;
        end
        if (state_reg == rgbconv_pkg::ST_MAC) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= kcoef * $signed({1'b0, tpx[16-8*ch +: 8]});
            end
        end
        if (prod_v_reg) begin
            for (int ch = 0; ch < 3; ch++) begin
                acc_reg[ch] <= acc_reg[ch] + AB'(prod_reg[ch]);
            end
        end
        if (state_reg == rgbconv_pkg::ST_OUT && !out_valid_reg) begin
            for (int ch = 0; ch < 3; ch++) acc_reg[ch] <= '0;
            if (xi_reg == nxs_reg - 2'd1) begin
                xi_reg <= '0;
                yi_reg <= yi_reg + 2'd1;
            end else begin
                xi_reg <= xi_reg + 2'd1;
            end
        end
        if (state_reg == rgbconv_pkg::ST_DIV && div_done[0]) begin
            out_reg.red_out     <= div_q[0];
            out_reg.green_out   <= div_q[1];
            out_reg.blue_out    <= div_q[2];
            out_reg.out_column  <= (xi_reg == 2'd0 && a_reg != '0) ? a_reg - CB'(1) : a_reg;
            out_reg.out_row     <= (yi_reg == 2'd0 && b_reg != '0) ? b_reg - RB'(1) : b_reg;
            out_reg.last_of_run <= (yi_reg == nys_reg - 2'd1 && xi_reg == nxs_reg - 2'd1);
            out_reg.frame_done  <= (yi_reg == nys_reg - 2'd1 && xi_reg == nxs_reg - 2'd1
                                    && {1'b0, a_reg} == w_eff - WB'(1)
                                    && b_reg == h_eff - RB'(1)
                                    && nxs_reg == 2'd1 + 2'((a_reg >= CB'(1)) ? 1 : 0) - 2'd0
                                    && ((nxs_reg == 2'd2) || (a_reg == '0))
                                    && ((nys_reg == 2'd2) || (b_reg == '0)));
        end
    end

    // divider starts once the last product is accumulated
    logic mac_last_reg;
    logic div_go_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_last_reg <= 1'b0;
        end else begin
            mac_last_reg <= prod_v_reg && (state_reg == rgbconv_pkg::ST_DIV) && !div_go_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_go_reg <= 1'b0;
        end else begin
            div_go_reg <= (state_reg == rgbconv_pkg::ST_DIV) && (mac_last_reg || div_go_reg)
                          && !div_done[0];
        end
    end

    always_comb begin
        div_ctrl.start   = mac_last_reg;
        div_ctrl.divisor = divisor_reg;
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        rgbconv_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (div_ctrl),
            .dividend (acc_reg[g]),
            .done     (div_done[g]),
            .quotient (div_q[g])
        );
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for rgb_convolution_clamped_edges: random bursty pixels,
// random result back-pressure, and an in-bench predictor of the 3x3 clamped filter.
// Depends on rgbconv_pkg and the top-level RTL only.
module tb;

    localparam int MAX_WIDTH = rgbconv_pkg::MAX_WIDTH;
    localparam int COEF_BITS = rgbconv_pkg::COEF_BITS;
    localparam int KREG_BITS = rgbconv_pkg::KREG_BITS;
    localparam int DIV_BITS  = rgbconv_pkg::DIV_BITS;
    localparam int COL_BITS  = rgbconv_pkg::COL_BITS;
    localparam int ROW_BITS  = rgbconv_pkg::ROW_BITS;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    rgbconv_pkg::pixel_in_t s_data;
    logic                 m_valid;
    logic                 m_ready;
    rgbconv_pkg::result_t m_data;
    logic                 cfg_we;
    logic [rgbconv_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [KREG_BITS-1:0] cfg_wdata;

    rgb_convolution_clamped_edges DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    localparam int SETTLE_CYCLES = 250;

    // predictor state
    logic [KREG_BITS-1:0] kernel_rows [3];
    logic [DIV_BITS-1:0]  divisor_reg;
    logic [12:0]          width_reg;
    logic [15:0]          height_reg;
    logic [23:0]          line_mem [0:2*MAX_WIDTH-1];
    logic [23:0]          window [0:8];
    int                   col_pos;
    int                   row_pos;

    rgbconv_pkg::result_t pending_results [$];
    int      pixels_sent;
    int      results_checked;
    int      mismatches;
    int      burst_left;
    bit      bursty;
    int      stall_pct;
    int      stall_max;
    int      stall_left;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    function automatic longint coef_at(int i, int j);
        logic signed [COEF_BITS-1:0] f;
        f = kernel_rows[j][COEF_BITS*i +: COEF_BITS];
        return longint'(f);
    endfunction

    function automatic rgbconv_pkg::result_t filter_window(int rsel, int csel);
        rgbconv_pkg::result_t r;
        longint    acc [3];
        longint    d;
        longint    q;
        longint    k;
        logic [23:0] px;
        int        wr;
        int        wc;
        r = '0;
        acc = '{0, 0, 0};
        d = (divisor_reg == 0) ? 1 : longint'(divisor_reg);
        for (int rr = 0; rr < 3; rr++) begin
            wr = rsel ? ((rr + 1 > 2) ? 2 : rr + 1) : rr;
            for (int cc = 0; cc < 3; cc++) begin
                wc = csel ? ((cc + 1 > 2) ? 2 : cc + 1) : cc;
                px = window[wc*3 + wr];
                k = coef_at(2 - cc, 2 - rr);
                for (int ch = 0; ch < 3; ch++)
                    acc[ch] += k * longint'(px[16 - 8*ch +: 8]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            q = acc[ch] / d;
            q = (q < 0) ? 0 : (q > 255) ? 255 : q;
            case (ch)
                0: r.red_out = q[7:0];
                1: r.green_out = q[7:0];
                default: r.blue_out = q[7:0];
            endcase
        end
        return r;
    endfunction

    function automatic void convolve_pixel(rgbconv_pkg::pixel_in_t p);
        int          w;
        int          h;
        int          idx;
        int          ys [2];
        int          xs [2];
        int          nys;
        int          nxs;
        logic [23:0] pix;
        logic [23:0] mid;
        logic [23:0] top;
        rgbconv_pkg::result_t r;
        w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg < 2) ? 2 : int'(height_reg);
        pix = {p.red_in, p.green_in, p.blue_in};
        idx = col_pos % MAX_WIDTH;
        mid = (row_pos >= 1) ? line_mem[idx] : pix;
        top = (row_pos >= 2) ? line_mem[MAX_WIDTH + idx] : mid;
        if (row_pos >= 1) line_mem[MAX_WIDTH + idx] = line_mem[idx];
        line_mem[idx] = pix;
        if (col_pos == 0) begin
            for (int c = 0; c < 3; c++) begin
                window[c*3] = top;
                window[c*3 + 1] = mid;
                window[c*3 + 2] = pix;
            end
        end else begin
            for (int i = 0; i < 6; i++) window[i] = window[i + 3];
            window[6] = top;
            window[7] = mid;
            window[8] = pix;
        end
        nys = 0;
        nxs = 0;
        if (row_pos >= 1) begin
            ys[nys] = row_pos - 1;
            nys = nys + 1;
        end
        if (row_pos == h - 1) begin
            ys[nys] = row_pos;
            nys = nys + 1;
        end
        if (col_pos >= 1) begin
            xs[nxs] = col_pos - 1;
            nxs = nxs + 1;
        end
        if (col_pos == w - 1) begin
            xs[nxs] = col_pos;
            nxs = nxs + 1;
        end
        for (int yi = 0; yi < nys; yi++) begin
            for (int xi = 0; xi < nxs; xi++) begin
                r = filter_window(yi, xi);
                r.out_column = xs[xi][COL_BITS-1:0];
                r.out_row = ys[yi][ROW_BITS-1:0];
                r.last_of_run = (yi == nys - 1 && xi == nxs - 1);
                r.frame_done = (xs[xi] == w - 1 && ys[yi] == h - 1);
                pending_results.push_back(r);
            end
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // receiver: stall in runs of random length
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, stall_max);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        rgbconv_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", m_data);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_data.red_out !== want.red_out || m_data.green_out !== want.green_out ||
                    m_data.blue_out !== want.blue_out ||
                    m_data.out_column !== want.out_column || m_data.out_row !== want.out_row ||
                    m_data.last_of_run !== want.last_of_run ||
                    m_data.frame_done !== want.frame_done) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
    end

    task automatic send_pixel(rgbconv_pkg::pixel_in_t p);
        int gap;
        if (bursty && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= p;
        do @(posedge aclk); while (!s_ready);
        convolve_pixel(p);
        pixels_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rgbconv_pkg::pixel_in_t random_pixel();
        rgbconv_pkg::pixel_in_t p;
        p.red_in = pick_channel();
        p.green_in = pick_channel();
        p.blue_in = pick_channel();
        return p;
    endfunction

    task automatic drain_and_settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(rgbconv_pkg::cfg_index_t idx, logic [KREG_BITS-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            rgbconv_pkg::REG_KROW_TOP:     kernel_rows[0] = value;
            rgbconv_pkg::REG_KROW_MID:     kernel_rows[1] = value;
            rgbconv_pkg::REG_KROW_BOTTOM:  kernel_rows[2] = value;
            rgbconv_pkg::REG_DIVISOR:      divisor_reg = value[DIV_BITS-1:0];
            rgbconv_pkg::REG_FRAME_WIDTH:  begin
                width_reg = value[12:0];
                col_pos = 0;
                row_pos = 0;
            end
            rgbconv_pkg::REG_FRAME_HEIGHT: begin
                height_reg = value[15:0];
                col_pos = 0;
                row_pos = 0;
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KREG_BITS-1:0] kernel_row(int c0, int c1, int c2);
        return {16'(c2), 16'(c1), 16'(c0)};
    endfunction

    task automatic set_kernel(logic [KREG_BITS-1:0] t, logic [KREG_BITS-1:0] m,
                              logic [KREG_BITS-1:0] b, int div);
        write_reg(rgbconv_pkg::REG_KROW_TOP, t);
        write_reg(rgbconv_pkg::REG_KROW_MID, m);
        write_reg(rgbconv_pkg::REG_KROW_BOTTOM, b);
        write_reg(rgbconv_pkg::REG_DIVISOR, KREG_BITS'(div));
    endtask

    task automatic set_frame(int w, int h);
        write_reg(rgbconv_pkg::REG_FRAME_WIDTH, KREG_BITS'(w));
        write_reg(rgbconv_pkg::REG_FRAME_HEIGHT, KREG_BITS'(h));
    endtask

    task automatic send_random(int n);
        repeat (n) send_pixel(random_pixel());
    endtask

    task automatic set_random_kernel(int div);
        set_kernel(KREG_BITS'({$urandom, $urandom}), KREG_BITS'({$urandom, $urandom}),
                   KREG_BITS'({$urandom, $urandom}), div);
    endtask

    task automatic test_reset_defaults();
        rgbconv_pkg::pixel_in_t p;
        bursty = 0;
        stall_pct = 0;
        p = '0;
        send_pixel(p);
        p = '1;
        send_pixel(p);
        send_random(4);
        drain_and_settle();
    endtask

    task automatic test_identity_small_frame();
        rgbconv_pkg::pixel_in_t p;
        set_frame(3, 3);
        for (int i = 0; i < 9; i++) begin
            p = (i % 2) ? '1 : '0;
            if (i == 4) p = 24'h12A5F0;
            send_pixel(p);
        end
        drain_and_settle();
    endtask

    task automatic test_clamped_sizes();
        set_frame(0, 1);
        send_random(8);
        drain_and_settle();
        set_frame(1, 0);
        send_random(4);
        drain_and_settle();
        set_frame(8191, 3);
        send_random(5);
        drain_and_settle();
        set_frame(4096, 2);
        send_random(3);
        drain_and_settle();
        set_frame(2, 65535);
        send_random(10);
        drain_and_settle();
    endtask

    task automatic test_kernel_extremes();
        bursty = 1;
        stall_pct = 30;
        stall_max = 5;
        set_kernel(kernel_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                   kernel_row(16'h7FFF, 16'h7FFF, 16'h7FFF),
                   kernel_row(16'h7FFF, 16'h7FFF, 16'h7FFF), 0);
        set_frame(4, 3);
        send_random(12);
        drain_and_settle();
        set_kernel(kernel_row(16'h8000, 16'h8000, 16'h8000),
                   kernel_row(16'h8000, 16'h7FFF, 16'h8000),
                   kernel_row(16'h8000, 16'h8000, 16'h8000), 65535);
        send_random(12);
        drain_and_settle();
        set_random_kernel($urandom_range(1, 65535));
        send_random(12);
        drain_and_settle();
    endtask

    task automatic test_random_frames(int target);
        int w;
        int h;
        int frames;
        int c [9];
        while (pixels_sent < target) begin
            bursty = ($urandom_range(0, 3) != 0);
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            stall_max = $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) begin
                set_random_kernel($urandom_range(0, 65535));
            end else begin
                foreach (c[i]) c[i] = $urandom_range(0, 16) - 8;
                set_kernel(kernel_row(c[0], c[1], c[2]), kernel_row(c[3], c[4], c[5]),
                           kernel_row(c[6], c[7], c[8]), $urandom_range(1, 24));
            end
            w = $urandom_range(2, 8);
            h = $urandom_range(2, 6);
            set_frame(w, h);
            frames = $urandom_range(1, 3);
            send_random(frames * w * h);
            // part of a frame, then restart through a size write
            if ($urandom_range(0, 2) == 0) send_random($urandom_range(1, w * h - 1));
            drain_and_settle();
        end
    endtask

    initial begin
        int wait_cycles;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        kernel_rows[0] = '0;
        kernel_rows[1] = KREG_BITS'(65536);
        kernel_rows[2] = '0;
        divisor_reg = 16'd1;
        width_reg = 13'd640;
        height_reg = 16'd480;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 9; i++) window[i] = '0;
        pixels_sent = 0;
        results_checked = 0;
        mismatches = 0;
        burst_left = 0;
        bursty = 0;
        stall_pct = 0;
        stall_max = 1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_identity_small_frame();
        test_clamped_sizes();
        test_kernel_extremes();
        test_random_frames(380);

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Sent %0d pixels over clamped, extreme and random frame sizes and kernels;",
                 pixels_sent);
        $display("checked %0d filtered results, %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end

endmodule
